// File: hw/rtl/stereo_echo_fir_feedback_defines.svh
// ----------------------------------------------------------------------------
// stereo echo assertion macros
// clocked assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef STEREO_ECHO_FIR_FEEDBACK_DEFINES_SVH
`define STEREO_ECHO_FIR_FEEDBACK_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SEFB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SEFB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SEFB_ASSERT_IMP(lbl, ante, cons, msg)

`define SEFB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/sefb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefb_pkg
// shared types, widths and the saturating mix helper of the stereo echo
// ----------------------------------------------------------------------------
package sefb_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 8;
   localparam int GAIN_W    = 8;
   localparam int TAPS      = 8;
   localparam int TAP_IDX_W = 3;
   localparam int TAP_BUS_W = TAPS * COEF_W;
   localparam int FIR_W     = SAMPLE_W + COEF_W + TAP_IDX_W;
   localparam int PROD_W    = FIR_W + GAIN_W;
   localparam int FRAC_BITS = 14;
   localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

   typedef enum logic [2:0] {
      CSR_DELAY,
      CSR_FEEDBACK,
      CSR_MIX_LEFT,
      CSR_MIX_RIGHT,
      CSR_TAPS_LOW,
      CSR_TAPS_HIGH
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MAC,
      ST_SCALE,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic                 push;
      logic                 clear;
      logic                 mac;
      logic [TAP_IDX_W-1:0] tap;
   } lane_ctrl_type;

   function automatic logic signed [SAMPLE_W-1:0] mix_sat(
      input logic signed [SAMPLE_W-1:0] x,
      input logic signed [PROD_W-1:0]   p
   );
      logic signed [PROD_W-1:0] shifted;
      logic signed [SUM_W-1:0]  s;
      logic signed [SAMPLE_W-1:0] r;
      shifted = p >>> FRAC_BITS;
      s = SUM_W'(x) + SUM_W'(shifted);
      if (!s[SUM_W-1] && (|s[SUM_W-2:SAMPLE_W-1])) begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (s[SUM_W-1] && !(&s[SUM_W-2:SAMPLE_W-1])) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         r = s[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/stereo_echo_fir_feedback.sv
`timescale 1ns / 1ps
`include "stereo_echo_fir_feedback_defines.svh"
// ----------------------------------------------------------------------------
// stereo_echo_fir_feedback
// stereo echo with delay ring, 8-tap filter per channel and feedback
// ----------------------------------------------------------------------------
// One stereo word is processed at a time. The ring entry is read into a
// register at the edge that accepts the word. Then come one step to push the
// echo sample into both lane histories, the per-lane multiply-accumulate (one
// tap per cycle), one step for the gain products and a last step for
// saturation, ring write-back and the loading of any result. Words are taken
// only in idle, so a new word is never accepted before the last one is done.
// A new word is taken as soon as the block is back in idle, even while a result
// still waits in the output register; a finished word that wants a result
// waits in its last step until that register is read. The ring needs no
// clearing pass after reset: a fill count marks the entries written so far,
// and any entry beyond it reads as zero. Registers are written through the
// csr port, which is always ready; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module stereo_echo_fir_feedback
   import sefb_pkg::*;
#(
   parameter int RING_ENTRIES      = 8192,
   parameter int ENTRIES_PER_LEVEL = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_in_left,
   input  logic signed [SAMPLE_W-1:0] req_in_right,
   input  logic                       req_want_output,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_out_left,
   output logic signed [SAMPLE_W-1:0] rsp_out_right,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_data
);

   localparam int PW     = $clog2(RING_ENTRIES);
   localparam int FILL_W = $clog2(RING_ENTRIES + 1);
   localparam int LIM_W  = 4 + $clog2(ENTRIES_PER_LEVEL + 1);
   localparam int CMP_W  = (LIM_W > PW + 1) ? LIM_W : PW + 1;
   localparam logic [CMP_W-1:0] RING_LIM = CMP_W'(RING_ENTRIES);
   localparam logic [CMP_W-1:0] LEVEL_LEN = CMP_W'(ENTRIES_PER_LEVEL);

   // configuration
   logic [3:0]               delay_level_ff;
   logic signed [GAIN_W-1:0] feedback_gain_ff;
   logic signed [GAIN_W-1:0] mix_gain_left_ff;
   logic signed [GAIN_W-1:0] mix_gain_right_ff;
   logic [31:0]              taps_low_ff;
   logic [31:0]              taps_high_ff;

   // control
   state_type                state_ff;
   state_type                state_in;
   logic [TAP_IDX_W-1:0]     tap_ff;
   logic [TAP_IDX_W-1:0]     tap_in;
   logic [PW-1:0]            pos_ff;
   logic [PW-1:0]            pos_in;
   logic [FILL_W-1:0]        fill_ff;
   logic [FILL_W-1:0]        fill_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   // word in flight
   logic signed [SAMPLE_W-1:0] x_l_ff;
   logic signed [SAMPLE_W-1:0] x_r_ff;
   logic                       want_ff;
   logic [PW-1:0]              wr_addr_ff;
   logic [2*SAMPLE_W-1:0]      rd_ff;
   logic                       rd_ok_ff;
   logic signed [SAMPLE_W-1:0] out_l_ff;
   logic signed [SAMPLE_W-1:0] out_r_ff;

   logic [2*SAMPLE_W-1:0]      ring_mem [RING_ENTRIES];

   logic                       req_fire;
   logic                       final_go;
   logic                       write_back;
   logic                       scale_en;
   lane_ctrl_type              lane_ctrl;
   logic [CMP_W-1:0]           limit;
   logic [CMP_W-1:0]           pos_plus;
   logic signed [SAMPLE_W-1:0] entry_l;
   logic signed [SAMPLE_W-1:0] entry_r;
   logic signed [FIR_W-1:0]    fir_l;
   logic signed [FIR_W-1:0]    fir_r;
   logic signed [SAMPLE_W-1:0] echo_l;
   logic signed [SAMPLE_W-1:0] echo_r;
   logic signed [SAMPLE_W-1:0] mix_l;
   logic signed [SAMPLE_W-1:0] mix_r;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_level_ff    <= '0;
         feedback_gain_ff  <= '0;
         mix_gain_left_ff  <= '0;
         mix_gain_right_ff <= '0;
         taps_low_ff       <= '0;
         taps_high_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DELAY:     delay_level_ff    <= csr_data[3:0];
            CSR_FEEDBACK:  feedback_gain_ff  <= signed'(csr_data[GAIN_W-1:0]);
            CSR_MIX_LEFT:  mix_gain_left_ff  <= signed'(csr_data[GAIN_W-1:0]);
            CSR_MIX_RIGHT: mix_gain_right_ff <= signed'(csr_data[GAIN_W-1:0]);
            CSR_TAPS_LOW:  taps_low_ff       <= csr_data;
            CSR_TAPS_HIGH: taps_high_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MAC;
         ST_MAC:   if (tap_ff == TAP_IDX_W'(TAPS - 1)) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_FINAL;
         ST_FINAL: if (final_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready       = 1'b0;
      lane_ctrl.push  = 1'b0;
      lane_ctrl.clear = 1'b0;
      lane_ctrl.mac   = 1'b0;
      lane_ctrl.tap   = tap_ff;
      scale_en        = 1'b0;
      write_back      = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_LOAD: begin
            lane_ctrl.push  = 1'b1;
            lane_ctrl.clear = 1'b1;
         end
         ST_MAC:   lane_ctrl.mac = 1'b1;
         ST_SCALE: scale_en = 1'b1;
         ST_FINAL: write_back = final_go;
         default: begin
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;
   // hold a finished word that wants a result while the previous result is still unread
   assign final_go = !(want_ff && rsp_valid_ff && !rsp_ready);

   assign limit    = CMP_W'(delay_level_ff) * LEVEL_LEN;
   assign pos_plus = CMP_W'(pos_ff) + CMP_W'(1);

   always_comb begin
      pos_in = pos_ff;
      if (state_ff == ST_LOAD) begin
         if (pos_plus >= limit || pos_plus >= RING_LIM) begin
            pos_in = '0;
         end else begin
            pos_in = pos_plus[PW-1:0];
         end
      end
   end

   always_comb begin
      tap_in = tap_ff;
      if (state_ff == ST_LOAD) begin
         tap_in = '0;
      end else if (state_ff == ST_MAC) begin
         tap_in = tap_ff + TAP_IDX_W'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (write_back && FILL_W'(wr_addr_ff) >= fill_ff) begin
         fill_in = FILL_W'(wr_addr_ff) + FILL_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (write_back && want_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_l_ff     <= req_in_left;
         x_r_ff     <= req_in_right;
         want_ff    <= req_want_output;
         wr_addr_ff <= pos_ff;
         rd_ok_ff   <= FILL_W'(pos_ff) < fill_ff;
      end
      if (write_back && want_ff) begin
         out_l_ff <= mix_l;
         out_r_ff <= mix_r;
      end
   end

   // echo ring, left in the upper half
   always_ff @(posedge clock) begin
      rd_ff <= ring_mem[pos_ff];
      if (write_back) begin
         ring_mem[wr_addr_ff] <= {echo_l, echo_r};
      end
   end

   // entries past the fill mark have never been written, so they read as zero here
   assign entry_l = rd_ok_ff ? signed'(rd_ff[2*SAMPLE_W-1:SAMPLE_W]) : '0;
   assign entry_r = rd_ok_ff ? signed'(rd_ff[SAMPLE_W-1:0]) : '0;

   sefb_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .sample (entry_l),
      .taps   ({taps_high_ff, taps_low_ff}),
      .fir    (fir_l)
   );

   sefb_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .sample (entry_r),
      .taps   ({taps_high_ff, taps_low_ff}),
      .fir    (fir_r)
   );

   sefb_merge u_merge (
      .clock          (clock),
      .scale_en       (scale_en),
      .fir_left       (fir_l),
      .fir_right      (fir_r),
      .feedback_gain  (feedback_gain_ff),
      .mix_gain_left  (mix_gain_left_ff),
      .mix_gain_right (mix_gain_right_ff),
      .x_left         (x_l_ff),
      .x_right        (x_r_ff),
      .echo_left      (echo_l),
      .echo_right     (echo_r),
      .mix_left       (mix_l),
      .mix_right      (mix_r)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;

   `SEFB_ASSERT_IMP(a_fill_bound, 1'b1, fill_ff <= FILL_W'(RING_ENTRIES), "fill beyond ring")
   `SEFB_ASSERT_IMP(a_rsp_from_final, $rose(rsp_valid), $past(state_ff == ST_FINAL), "stray result")
   `SEFB_ASSERT_NXT(a_written_valid, write_back, FILL_W'(wr_addr_ff) < fill_ff, "fill short")

endmodule

// File: hw/rtl/sefb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefb_lane
// one channel of the echo filter: 8-deep sample history and a serial
// multiply-accumulate that walks the taps one per cycle
// ----------------------------------------------------------------------------
module sefb_lane
   import sefb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  lane_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [TAP_BUS_W-1:0]       taps,
   output logic signed [FIR_W-1:0]    fir
);

   logic signed [SAMPLE_W-1:0]        hist_ff [TAPS];
   logic signed [FIR_W-1:0]           acc_ff;
   logic signed [FIR_W-1:0]           acc_in;
   logic [TAP_IDX_W-1:0]              coef_idx;
   logic signed [COEF_W-1:0]          coef;
   logic signed [SAMPLE_W+COEF_W-1:0] prod;

   // newest sample takes the highest coefficient
   assign coef_idx = ~ctrl.tap;
   assign coef     = signed'(taps[{coef_idx, 3'b000} +: COEF_W]);
   assign prod     = hist_ff[ctrl.tap] * coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (ctrl.push) begin
         hist_ff[0] <= sample;
         for (int i = 1; i < TAPS; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.mac) begin
         acc_in = acc_ff + FIR_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign fir = acc_ff;

endmodule

// File: hw/rtl/sefb_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sefb_merge
// combines the two lane sums: feedback and mix gains, shift and saturation
// ----------------------------------------------------------------------------
module sefb_merge
   import sefb_pkg::*;
(
   input  logic                       clock,
   input  logic                       scale_en,
   input  logic signed [FIR_W-1:0]    fir_left,
   input  logic signed [FIR_W-1:0]    fir_right,
   input  logic signed [GAIN_W-1:0]   feedback_gain,
   input  logic signed [GAIN_W-1:0]   mix_gain_left,
   input  logic signed [GAIN_W-1:0]   mix_gain_right,
   input  logic signed [SAMPLE_W-1:0] x_left,
   input  logic signed [SAMPLE_W-1:0] x_right,
   output logic signed [SAMPLE_W-1:0] echo_left,
   output logic signed [SAMPLE_W-1:0] echo_right,
   output logic signed [SAMPLE_W-1:0] mix_left,
   output logic signed [SAMPLE_W-1:0] mix_right
);

   logic signed [PROD_W-1:0] fb_l_ff;
   logic signed [PROD_W-1:0] fb_r_ff;
   logic signed [PROD_W-1:0] mx_l_ff;
   logic signed [PROD_W-1:0] mx_r_ff;

   always_ff @(posedge clock) begin
      if (scale_en) begin
         fb_l_ff <= PROD_W'(fir_left)  * PROD_W'(feedback_gain);
         fb_r_ff <= PROD_W'(fir_right) * PROD_W'(feedback_gain);
         mx_l_ff <= PROD_W'(fir_left)  * PROD_W'(mix_gain_left);
         mx_r_ff <= PROD_W'(fir_right) * PROD_W'(mix_gain_right);
      end
   end

   assign echo_left  = mix_sat(x_left,  fb_l_ff);
   assign echo_right = mix_sat(x_right, fb_r_ff);
   assign mix_left   = mix_sat(x_left,  mx_l_ff);
   assign mix_right  = mix_sat(x_right, mx_r_ff);

endmodule

// File: test/stereo_echo_fir_feedback_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_echo_fir_feedback_tb
// self-checking bench for the stereo echo: a directed table at reset and at
// extreme register values, then random phases at delays 15, 1 and 0. every
// accepted word runs through a local echo predictor and each result is
// checked in order against it or against the directed table, with bursty input and a stalling output
// ----------------------------------------------------------------------------
module stereo_echo_fir_feedback_tb;
   import sefb_pkg::*;

   localparam int RING_ENTRIES      = 8192;
   localparam int ENTRIES_PER_LEVEL = 512;
   localparam int SETTLE_CYCLES     = 24;
   localparam int HOLD_CYCLES       = 400;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int DIRECTED_ROWS     = 24;
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } stereo_pair_type;

   typedef struct {
      logic [3:0]  delay;
      logic [7:0]  feedback;
      logic [7:0]  mix_left;
      logic [7:0]  mix_right;
      logic [31:0] taps_low;
      logic [31:0] taps_high;
   } echo_cfg_type;

   typedef struct {
      int                 cfg;
      logic signed [15:0] left;
      logic signed [15:0] right;
      bit                 want;
      bit                 typed;
      logic signed [15:0] exp_left;
      logic signed [15:0] exp_right;
   } directed_row_type;

   typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_in_left = '0;
   logic signed [15:0] req_in_right = '0;
   logic req_want_output = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_left;
   logic signed [15:0] rsp_out_right;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   stereo_echo_fir_feedback #(
      .RING_ENTRIES(RING_ENTRIES),
      .ENTRIES_PER_LEVEL(ENTRIES_PER_LEVEL)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_left(req_in_left),
      .req_in_right(req_in_right),
      .req_want_output(req_want_output),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_left(rsp_out_left),
      .rsp_out_right(rsp_out_right),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] ring_left [RING_ENTRIES];
   logic signed [15:0] ring_right [RING_ENTRIES];
   int unsigned        ring_pos;
   logic signed [15:0] hist_left [8];
   logic signed [15:0] hist_right [8];
   logic [2:0]         hist_ix;
   logic [3:0]         m_delay;
   logic signed [7:0]  m_feedback;
   logic signed [7:0]  m_mix_left;
   logic signed [7:0]  m_mix_right;
   logic [31:0]        m_taps_low;
   logic [31:0]        m_taps_high;

   stereo_pair_type pending_pairs[$];
   int mismatches = 0;
   int words_sent = 0;
   int pairs_checked = 0;
   int csr_writes = 0;
   int cycles = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rx_count = 0;
   rx_mode_type rx_mode = RX_OPEN;

   directed_row_type directed [DIRECTED_ROWS];
   echo_cfg_type     directed_cfg [2];

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint tap_coef(input int k);
      logic [31:0] w;
      w = (k < 4) ? m_taps_low : m_taps_high;
      return longint'($signed(w[(k % 4) * 8 +: 8]));
   endfunction

   task automatic model_csr(input logic [2:0] idx, input logic [31:0] d);
      case (idx)
         CSR_DELAY:     m_delay = d[3:0];
         CSR_FEEDBACK:  m_feedback = d[7:0];
         CSR_MIX_LEFT:  m_mix_left = d[7:0];
         CSR_MIX_RIGHT: m_mix_right = d[7:0];
         CSR_TAPS_LOW:  m_taps_low = d;
         CSR_TAPS_HIGH: m_taps_high = d;
         default: ;
      endcase
   endtask

   task automatic echo_step(input logic signed [15:0] xl, input logic signed [15:0] xr,
                            output stereo_pair_type o);
      int unsigned p;
      longint fl;
      longint fr;
      int k;
      int slot;
      p = ring_pos;
      if (p >= RING_ENTRIES) p = 0;
      ring_pos = p + 1;
      if (ring_pos >= int'(m_delay) * ENTRIES_PER_LEVEL || ring_pos >= RING_ENTRIES)
         ring_pos = 0;
      hist_left[hist_ix] = ring_left[p];
      hist_right[hist_ix] = ring_right[p];
      fl = 0;
      fr = 0;
      for (k = 0; k < 8; k++) begin
         slot = (int'(hist_ix) + k) % 8;
         fl += longint'(hist_left[slot]) * tap_coef(7 - k);
         fr += longint'(hist_right[slot]) * tap_coef(7 - k);
      end
      hist_ix = hist_ix - 3'd1;
      ring_left[p] = clip16(longint'(xl) + ((fl * longint'(m_feedback)) >>> 14));
      ring_right[p] = clip16(longint'(xr) + ((fr * longint'(m_feedback)) >>> 14));
      o.left = clip16(longint'(xl) + ((fl * longint'(m_mix_left)) >>> 14));
      o.right = clip16(longint'(xr) + ((fr * longint'(m_mix_right)) >>> 14));
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3, 4: return 16'($urandom());
         default: return 16'($urandom_range(0, 16383) - 8192);
      endcase
   endfunction

   function automatic logic [7:0] rand_gain();
      if ($urandom_range(0, 3) == 0) return 8'($urandom());
      return 8'($urandom_range(0, 63) - 32);
   endfunction

   function automatic bit count_fault();
      mismatches++;
      return mismatches <= 10;
   endfunction

   task automatic send_word(input logic signed [15:0] l, input logic signed [15:0] r,
                            input bit w, input bit typed,
                            input logic signed [15:0] el, input logic signed [15:0] er);
      stereo_pair_type predicted;
      @(negedge clock);
      req_valid = 1'b1;
      req_in_left = l;
      req_in_right = r;
      req_want_output = w;
      do @(posedge clock); while (!req_ready);
      echo_step(l, r, predicted);
      if (w) begin
         if (typed) pending_pairs.push_back('{el, er});
         else pending_pairs.push_back(predicted);
      end
      words_sent++;
   endtask

   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_in_left = 16'($urandom());
         req_in_right = 16'($urandom());
         req_want_output = 1'($urandom());
      end
   endtask

   task automatic wait_drained();
      idle_sender(1);
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] d);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = d;
      do @(posedge clock); while (!csr_ready);
      model_csr(idx, d);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // unused upper bits carry noise, spare indexes must be ignored
   task automatic apply_config(input echo_cfg_type c);
      wait_drained();
      csr_write(CSR_DELAY, ($urandom() & 32'hffff_fff0) | 32'(c.delay));
      csr_write(CSR_FEEDBACK, ($urandom() & 32'hffff_ff00) | 32'(c.feedback));
      csr_write(CSR_MIX_LEFT, ($urandom() & 32'hffff_ff00) | 32'(c.mix_left));
      csr_write(CSR_MIX_RIGHT, ($urandom() & 32'hffff_ff00) | 32'(c.mix_right));
      csr_write(CSR_TAPS_LOW, c.taps_low);
      csr_write(CSR_TAPS_HIGH, c.taps_high);
      csr_write(CSR_SPARE_A, $urandom());
      csr_write(CSR_SPARE_B, $urandom());
   endtask

   task automatic run_random(input int count, input bit pause_mid, input bit long_hold);
      int done;
      int burst;
      int k;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(1, 24);
         for (k = 0; k < burst && done < count; k++) begin
            send_word(rand_sample(), rand_sample(), $urandom_range(0, 3) != 0, 1'b0,
                      16'sh0000, 16'sh0000);
            done++;
            if (long_hold && done == count / 4) hold_asks++;
            if (pause_mid && done == count / 2) wait_drained();
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 16));
      end
   endtask

   // receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
         rsp_ready = 1'b0;
      end else begin
         rx_count++;
         if (rx_count % 64 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_OPEN:     rsp_ready = 1'b1;
            RX_COIN:     rsp_ready = 1'($urandom());
            RX_PERIODIC: rsp_ready = (rx_count % 8) != 0;
            RX_SPARSE:   rsp_ready = (rx_count % 4) == 0;
            default:     rsp_ready = 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      stereo_pair_type want_pair;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            if (count_fault())
               $display("unexpected result word %0d/%0d", rsp_out_left, rsp_out_right);
         end else begin
            want_pair = pending_pairs.pop_front();
            if (rsp_out_left !== want_pair.left || rsp_out_right !== want_pair.right) begin
               if (count_fault())
                  $display("mismatch on result %0d: left exp %0d got %0d, right exp %0d got %0d",
                           pairs_checked, want_pair.left, rsp_out_left,
                           want_pair.right, rsp_out_right);
            end
            pairs_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_pairs.size());
         $display("stereo_echo_fir_feedback verification failed");
         $finish;
      end
   end

   initial begin
      echo_cfg_type c;
      int i;
      for (i = 0; i < RING_ENTRIES; i++) begin
         ring_left[i] = '0;
         ring_right[i] = '0;
      end
      for (i = 0; i < 8; i++) begin
         hist_left[i] = '0;
         hist_right[i] = '0;
      end
      ring_pos = 0;
      hist_ix = '0;
      m_delay = '0;
      m_feedback = '0;
      m_mix_left = '0;
      m_mix_right = '0;
      m_taps_low = '0;
      m_taps_high = '0;

      // zero delay with every gain and tap at an extreme
      directed_cfg[0] = '{4'd0, 8'h80, 8'h7f, 8'h80, 32'h8080_8080, 32'h7f7f_7f7f};
      directed_cfg[1] = '{4'd0, 8'h7f, 8'h80, 8'h7f, 32'h7f7f_7f7f, 32'h8080_8080};

      // at reset all gains are zero, so the output is the input
      directed = '{
         '{-1, 16'sh7fff, 16'sh8000, 1'b1, 1'b1, 16'sh7fff, 16'sh8000},
         '{-1, 16'sh8000, 16'sh7fff, 1'b1, 1'b1, 16'sh8000, 16'sh7fff},
         '{-1, 16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'sh0000, 16'sh0000},
         '{-1, 16'shffff, 16'sh0001, 1'b1, 1'b1, 16'shffff, 16'sh0001},
         '{-1, 16'sh1234, 16'shedcb, 1'b0, 1'b1, 16'sh0000, 16'sh0000},
         '{-1, 16'sh5555, 16'shaaaa, 1'b1, 1'b1, 16'sh5555, 16'shaaaa},
         '{-1, 16'shaaaa, 16'sh5555, 1'b1, 1'b1, 16'shaaaa, 16'sh5555},
         '{-1, 16'sh0001, 16'shffff, 1'b1, 1'b1, 16'sh0001, 16'shffff},
         '{ 0, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh7fff, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{ 1, 16'sh7fff, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh7fff, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh8000, 16'sh7fff, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'shffff, 16'sh0001, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
         '{-1, 16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'sh0000, 16'sh0000}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed[i].cfg >= 0) apply_config(directed_cfg[directed[i].cfg]);
         send_word(directed[i].left, directed[i].right, directed[i].want,
                   directed[i].typed, directed[i].exp_left, directed[i].exp_right);
      end

      // longest delay, the position runs just past one level
      c.delay = 4'd15;
      c.feedback = rand_gain();
      c.mix_left = rand_gain();
      c.mix_right = rand_gain();
      c.taps_low = {rand_gain(), rand_gain(), rand_gain(), rand_gain()};
      c.taps_high = {rand_gain(), rand_gain(), rand_gain(), rand_gain()};
      apply_config(c);
      run_random(520, 1'b1, 1'b1);

      // shortened delay: wraps at once, then echoes return every 512 words
      c.delay = 4'd1;
      c.feedback = rand_gain();
      c.mix_left = rand_gain();
      c.mix_right = rand_gain();
      c.taps_low = {rand_gain(), rand_gain(), rand_gain(), rand_gain()};
      c.taps_high = {rand_gain(), rand_gain(), rand_gain(), rand_gain()};
      apply_config(c);
      run_random(540, 1'b0, 1'b1);

      c.delay = 4'd0;
      c.feedback = 8'($urandom());
      c.mix_left = 8'($urandom());
      c.mix_right = 8'($urandom());
      c.taps_low = $urandom();
      c.taps_high = $urandom();
      apply_config(c);
      run_random(60, 1'b0, 1'b0);

      wait_drained();
      $display("sent %0d words, checked %0d results, %0d register writes",
               words_sent, pairs_checked, csr_writes);
      $display("delays 0, 1 and 15 with a shortened delay, extreme gains and long output stalls");
      if (mismatches == 0 && pending_pairs.size() == 0) begin
         $display("stereo_echo_fir_feedback verification clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("stereo_echo_fir_feedback verification failed");
      end
      $finish;
   end

endmodule
